// File: rtl/xrru_pkg.sv
// Shared types, constants and the xorshift step for the random range unit.
`default_nettype none

package xrru_pkg;

  localparam int unsigned XRRU_WORD_W = 64;
  localparam int unsigned XRRU_DIV_W  = 33;
  localparam int unsigned XRRU_RES_W  = 40;
  localparam int unsigned XRRU_CNT_W  = $clog2(XRRU_WORD_W);

  localparam int unsigned XRRU_MAX_DICE = 256;

  localparam logic [XRRU_WORD_W-1:0] XRRU_DEFAULT_SEED = 64'd88172645463325252;
  localparam logic [XRRU_RES_W-1:0]  XRRU_SUM_MAX      = 40'h7F_FFFF_FFFF;

  localparam int unsigned XRRU_SHIFT_A = 13;
  localparam int unsigned XRRU_SHIFT_B = 7;
  localparam int unsigned XRRU_SHIFT_C = 17;

  typedef enum logic [2:0] {
    MODE_RAW      = 3'd0,
    MODE_RANGE    = 3'd1,
    MODE_BOOL     = 3'd2,
    MODE_CHANCE   = 3'd3,
    MODE_DICE     = 3'd4,
    MODE_DICE_SUM = 3'd5,
    MODE_SEED     = 3'd6,
    MODE_RESERVED = 3'd7
  } xrru_mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAW,
    ST_DIV,
    ST_FINISH
  } xrru_state_e;

  // Status the remainder unit reports back to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } xrru_div_status_t;

  // One xorshift step: left 13, right 7, left 17.
  function automatic logic [XRRU_WORD_W-1:0] xrru_xorshift(input logic [XRRU_WORD_W-1:0] s);
    logic [XRRU_WORD_W-1:0] x;
    x = s;
    x = x ^ (x << XRRU_SHIFT_A);
    x = x ^ (x >> XRRU_SHIFT_B);
    x = x ^ (x << XRRU_SHIFT_C);
    return x;
  endfunction

endpackage

`default_nettype wire

// File: rtl/xrru_req_if.sv
// Request channel: one word per request, valid/ready handshake.
`default_nettype none

interface xrru_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         mode;
  logic signed [31:0] first_operand;
  logic signed [31:0] second_operand;
  logic [32:0]        probability;
  logic [63:0]        seed_value;

  modport source (
    output valid, mode, first_operand, second_operand, probability, seed_value,
    input  ready
  );
  modport sink (
    input  valid, mode, first_operand, second_operand, probability, seed_value,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/xrru_rsp_if.sv
// Response channel: one result word per request, valid/ready handshake.
`default_nettype none

interface xrru_rsp_if;
  logic               valid;
  logic               ready;
  logic [63:0]        random_word;
  logic signed [39:0] integer_result;
  logic               flag;

  modport source (
    output valid, random_word, integer_result, flag,
    input  ready
  );
  modport sink (
    input  valid, random_word, integer_result, flag,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/xorshift_random_range_unit_core.sv
// Top level of the xorshift random range unit: sequencer, generator state and output word.
//
// Requests arrive as words on req_i and results leave as words on rsp_o, both
// with a valid/ready handshake. Every request yields exactly one result word.
// A request is taken only while the sequencer is idle; the result is parked in
// an output register, so the next request can be taken while the previous
// result still waits for the receiver. If the receiver stalls and a new
// result is finished, the sequencer holds in its final state until the output
// register frees up.
// Sequence of states: raw, bool and chance go from idle through a draw to the
// final state, where the result register is loaded; seed and the reserved mode
// go straight from idle to the final state. Range and dice add a pass through
// the bit-serial remainder unit after the draw, ending with its done flag. A
// dice sum repeats the draw and the remainder pass for every die, since every
// die needs its own. The next request is taken in the cycle after the load.
// The default_seed register is written through cfg_we_i/cfg_wdata_i and is
// only sampled on the first draw after reset when no seed request came first.
// Reset clears the generator state to zero, marks it unseeded, restores the
// default seed and empties the output register.
`default_nettype none

module xorshift_random_range_unit_core #(
  parameter int unsigned MAX_DICE = xrru_pkg::XRRU_MAX_DICE
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [63:0] cfg_wdata_i,
  xrru_req_if.sink         req_i,
  xrru_rsp_if.source       rsp_o
);
  import xrru_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_DICE + 1);
  localparam logic [31:0] MaxDiceW = 32'(MAX_DICE);

  xrru_state_e state_q, state_d;

  logic [XRRU_WORD_W-1:0] default_seed_q;
  logic [XRRU_WORD_W-1:0] gen_q;
  logic                   seeded_q;

  // Request held for the duration of its work.
  xrru_mode_e             mode_q;
  logic signed [31:0]     lo_q;
  logic [XRRU_DIV_W-1:0]  divisor_q;
  logic [32:0]            prob_q;
  logic [CntW-1:0]        count_q;

  // Working result.
  logic [XRRU_WORD_W-1:0] word_q;
  logic [XRRU_RES_W-1:0]  value_q;
  logic                   flag_q;

  // Output register.
  logic                   out_valid_q;
  logic [XRRU_WORD_W-1:0] out_word_q;
  logic [XRRU_RES_W-1:0]  out_value_q;
  logic                   out_flag_q;

  logic                   req_accept;
  logic                   out_free;
  logic                   out_load;
  logic                   div_start;
  logic                   needs_div;
  logic                   last_die;
  xrru_mode_e             req_mode;
  logic [XRRU_WORD_W-1:0] next_word;

  xrru_div_status_t       div_stat;
  logic [XRRU_DIV_W-1:0]  div_rem;

  // Request decode.
  logic signed [31:0]     a_op;
  logic signed [31:0]     b_op;
  logic signed [31:0]     lo_sel;
  logic signed [31:0]     hi_sel;
  logic [XRRU_DIV_W-1:0]  span;
  logic [XRRU_DIV_W-1:0]  sides;
  logic [CntW-1:0]        count_in;

  // Accumulation.
  logic [XRRU_DIV_W-1:0]  roll;
  logic [XRRU_RES_W:0]    sum_wide;
  logic [XRRU_RES_W-1:0]  range_value;

  assign req_mode = xrru_mode_e'(req_i.mode);
  assign a_op     = req_i.first_operand;
  assign b_op     = req_i.second_operand;

  always_comb begin
    if (a_op > b_op) begin
      lo_sel = b_op;
      hi_sel = a_op;
    end else begin
      lo_sel = a_op;
      hi_sel = b_op;
    end
    // The span can reach two to the 32, so it is formed at 33 bits.
    span = ({hi_sel[31], hi_sel} - {lo_sel[31], lo_sel}) + 33'd1;

    if (b_op[31] || (b_op == '0)) begin
      sides = 33'd1;
    end else begin
      sides = {1'b0, b_op};
    end

    if (a_op[31] || (a_op == '0) || (req_mode != MODE_DICE_SUM)) begin
      count_in = CntW'(1);
    end else if (a_op > $signed(MaxDiceW)) begin
      count_in = CntW'(MAX_DICE);
    end else begin
      count_in = CntW'(a_op);
    end
  end

  // The first draw after reset takes the default seed unless a seed came first.
  assign next_word = xrru_xorshift(seeded_q ? gen_q : default_seed_q);

  assign needs_div = (mode_q == MODE_RANGE) || (mode_q == MODE_DICE) ||
                     (mode_q == MODE_DICE_SUM);
  assign last_die  = (mode_q != MODE_DICE_SUM) || (count_q == CntW'(1));
  assign out_free  = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    req_i.ready = 1'b0;
    div_start   = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          if ((req_mode == MODE_SEED) || (req_mode == MODE_RESERVED)) begin
            state_d = ST_FINISH;
          end else begin
            state_d = ST_DRAW;
          end
        end
      end
      ST_DRAW: begin
        if (needs_div) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_d = last_die ? ST_FINISH : ST_DRAW;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign req_accept = req_i.valid && req_i.ready;

  xrru_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (next_word),
    .divisor_i   (divisor_q),
    .status_o    (div_stat),
    .remainder_o (div_rem)
  );

  // A roll is one plus the remainder; the dice sum saturates at 2^39 - 1.
  assign roll        = div_rem + 33'd1;
  assign sum_wide    = {1'b0, value_q} + {8'b0, roll};
  assign range_value = {{8{lo_q[31]}}, lo_q} + {7'b0, div_rem};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_seed_q <= XRRU_DEFAULT_SEED;
      gen_q          <= '0;
      seeded_q       <= 1'b0;
      count_q        <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        default_seed_q <= cfg_wdata_i;
      end
      if (req_accept) begin
        count_q <= count_in;
        if (req_mode == MODE_SEED) begin
          gen_q    <= req_i.seed_value;
          seeded_q <= 1'b1;
        end
      end
      if (state_q == ST_DRAW) begin
        gen_q    <= next_word;
        seeded_q <= 1'b1;
      end
      if ((state_q == ST_DIV) && div_stat.done && !last_die) begin
        count_q <= count_q - 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_accept) begin
      mode_q    <= req_mode;
      lo_q      <= lo_sel;
      prob_q    <= req_i.probability;
      divisor_q <= (req_mode == MODE_RANGE) ? span : sides;
      word_q    <= '0;
      value_q   <= '0;
      flag_q    <= 1'b0;
    end
    if (state_q == ST_DRAW) begin
      word_q <= next_word;
      case (mode_q)
        MODE_BOOL:   flag_q <= next_word[0];
        MODE_CHANCE: flag_q <= ({1'b0, next_word[63:32]} < prob_q);
        default:     flag_q <= 1'b0;
      endcase
    end
    if ((state_q == ST_DIV) && div_stat.done) begin
      case (mode_q)
        MODE_RANGE: value_q <= range_value;
        MODE_DICE:  value_q <= {7'b0, roll};
        MODE_DICE_SUM: begin
          if (sum_wide > {1'b0, XRRU_SUM_MAX}) begin
            value_q <= XRRU_SUM_MAX;
          end else begin
            value_q <= sum_wide[XRRU_RES_W-1:0];
          end
        end
        default: value_q <= '0;
      endcase
    end
    if (out_load) begin
      out_word_q  <= word_q;
      out_value_q <= value_q;
      out_flag_q  <= flag_q;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.random_word    = out_word_q;
  assign rsp_o.integer_result = $signed(out_value_q);
  assign rsp_o.flag           = out_flag_q;

`ifndef SYNTHESIS
  // The remainder unit is only started when it is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni) div_start |-> !div_stat.busy)
    else $error("remainder unit started while busy");

  // A finished remainder is only reported while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == ST_DIV))
    else $error("remainder finished outside of the divide state");

  // Any request in flight has at least one die left to roll.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (count_q != '0))
    else $error("die count ran down to zero");

  // A seed request marks the generator as seeded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_accept && (req_mode == MODE_SEED)) |=> seeded_q)
    else $error("seed request did not mark the generator seeded");

  // A result is only loaded when the output register can take it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !rsp_o.ready) |-> !out_load)
    else $error("result loaded over a stalled output word");
`endif

endmodule

`default_nettype wire

// File: rtl/xrru_divider.sv
// Bit-serial restoring remainder unit: 64-bit dividend modulo a 33-bit divisor.
`default_nettype none

module xrru_divider (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic [xrru_pkg::XRRU_WORD_W-1:0] dividend_i,
  input  wire logic [xrru_pkg::XRRU_DIV_W-1:0]  divisor_i,
  output xrru_pkg::xrru_div_status_t            status_o,
  output logic [xrru_pkg::XRRU_DIV_W-1:0]       remainder_o
);
  import xrru_pkg::*;

  logic [XRRU_WORD_W-1:0] dividend_q;
  logic [XRRU_DIV_W-1:0]  divisor_q;
  logic [XRRU_DIV_W-1:0]  rem_q;
  logic [XRRU_DIV_W-1:0]  rem_d;
  logic [XRRU_CNT_W-1:0]  cnt_q;
  logic                   busy_q;
  logic                   done_q;
  logic [XRRU_DIV_W:0]    shifted;
  logic [XRRU_DIV_W:0]    trial;

  // One quotient bit per cycle; the remainder always stays below the divisor.
  always_comb begin
    shifted = {rem_q, dividend_q[XRRU_WORD_W-1]};
    trial   = shifted - {1'b0, divisor_q};
    if (shifted >= {1'b0, divisor_q}) begin
      rem_d = trial[XRRU_DIV_W-1:0];
    end else begin
      rem_d = shifted[XRRU_DIV_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= XRRU_CNT_W'(XRRU_WORD_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dividend_q <= dividend_i;
      divisor_q  <= divisor_i;
      rem_q      <= '0;
    end else if (busy_q) begin
      dividend_q <= {dividend_q[XRRU_WORD_W-2:0], 1'b0};
      rem_q      <= rem_d;
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign remainder_o   = rem_q;

endmodule

`default_nettype wire

// File: sim/xorshift_random_range_unit_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the xorshift random range unit core.
module xorshift_random_range_unit_core_tb;
  import xrru_pkg::*;

  localparam int RESET_CYCLES     = 7;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES     = 100;
  localparam int BURST_MAX        = 14;

  localparam logic [31:0] INT32_MIN = 32'h8000_0000;
  localparam logic [31:0] INT32_MAX = 32'h7FFF_FFFF;
  localparam logic [32:0] PROB_ONE  = 33'h1_0000_0000;

  // One request word as the sender presents it.
  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] first_op;
    logic [31:0] second_op;
    logic [32:0] prob;
    logic [63:0] seed;
  } req_item_t;

  // One result word as the receiver sees it.
  typedef struct packed {
    logic [63:0] word;
    logic [39:0] value;
    logic        flag;
  } draw_result_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [63:0] cfg_wdata;

  xrru_req_if req_if ();
  xrru_rsp_if rsp_if ();

  xorshift_random_range_unit_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  // Requests waiting to be offered, and results the predictor has worked out
  // but the block has not delivered yet.
  req_item_t    pending_q[$];
  draw_result_t expected_q[$];

  // The predictor's own copy of the generator and its seed register.
  logic [63:0] gen_state;
  logic        gen_seeded;
  logic [63:0] boot_seed;

  logic req_fire;
  int   send_gap;
  int   stall_left;
  int   hold_left;
  int   hold_token;
  int   hold_served;
  bit   quiet_tail;

  int error_count;
  int results_checked;
  int mode_count[8];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs or loses a word.
  initial begin
    #15_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Advances the generator by one step. The first draw after reset loads the
  // seed register, unless a seed request has already set the state.
  function automatic logic [63:0] advance_state();
    logic [63:0] x;
    if (!gen_seeded) begin
      gen_state  = boot_seed;
      gen_seeded = 1'b1;
    end
    x = gen_state;
    x = x ^ (x << XRRU_SHIFT_A);
    x = x ^ (x >> XRRU_SHIFT_B);
    x = x ^ (x << XRRU_SHIFT_C);
    gen_state = x;
    return x;
  endfunction

  // Sides below one count as a single side.
  function automatic logic [63:0] clamp_sides(logic [31:0] raw);
    if (raw[31] || raw == 32'd0) return 64'd1;
    return {32'd0, raw};
  endfunction

  // Works out the result word that one accepted request must produce.
  function automatic draw_result_t predict_draw(req_item_t it);
    draw_result_t      r;
    logic signed [63:0] lo;
    logic signed [63:0] hi;
    logic signed [63:0] swap;
    logic [63:0]        span;
    logic [63:0]        sides;
    logic [63:0]        total;
    logic [63:0]        sum_value;
    int                 dice;
    r = '0;
    case (it.mode)
      MODE_RAW: r.word = advance_state();
      MODE_RANGE: begin
        lo = {{32{it.first_op[31]}}, it.first_op};
        hi = {{32{it.second_op[31]}}, it.second_op};
        if (lo > hi) begin
          swap = lo;
          lo   = hi;
          hi   = swap;
        end
        // The span reaches 2^32 for the full signed range, so it is kept at 64 bits.
        span      = hi - lo + 64'd1;
        r.word    = advance_state();
        sum_value = lo + (r.word % span);
        r.value   = sum_value[39:0];
      end
      MODE_BOOL: begin
        r.word = advance_state();
        r.flag = r.word[0];
      end
      MODE_CHANCE: begin
        r.word = advance_state();
        r.flag = ({1'b0, r.word[63:32]} < it.prob);
      end
      MODE_DICE: begin
        sides     = clamp_sides(it.second_op);
        r.word    = advance_state();
        sum_value = 64'd1 + (r.word % sides);
        r.value   = sum_value[39:0];
      end
      MODE_DICE_SUM: begin
        sides = clamp_sides(it.second_op);
        if (it.first_op[31] || it.first_op == 32'd0) dice = 1;
        else if (it.first_op > XRRU_MAX_DICE) dice = XRRU_MAX_DICE;
        else dice = int'(it.first_op);
        total = 64'd0;
        for (int i = 0; i < dice; i++) begin
          r.word = advance_state();
          total  = total + 64'd1 + (r.word % sides);
          if (total > {24'd0, XRRU_SUM_MAX}) total = {24'd0, XRRU_SUM_MAX};
        end
        r.value = total[39:0];
      end
      MODE_SEED: begin
        gen_state  = it.seed;
        gen_seeded = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------

  function automatic void push_req(logic [2:0] mode, logic [31:0] a, logic [31:0] b,
                                   logic [32:0] p, logic [63:0] s);
    req_item_t it;
    it.mode      = mode;
    it.first_op  = a;
    it.second_op = b;
    it.prob      = p;
    it.seed      = s;
    pending_q.push_back(it);
  endfunction

  // Mostly dice a person would throw, with the clamped and the widest cases mixed in.
  function automatic logic [31:0] random_sides();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return $urandom_range(1, 20);
    if (pick < 70) return $urandom_range(0, 3) - 2;
    if (pick < 75) return INT32_MAX;
    return $urandom_range(0, 32'h7FFF_FFFF);
  endfunction

  // A request with random content; every field is random even where the mode
  // ignores it, so that all payload bits toggle.
  function automatic req_item_t random_request();
    req_item_t it;
    int        pick;
    int        sub;
    it.first_op  = $urandom();
    it.second_op = $urandom();
    it.prob      = {1'($urandom_range(0, 1)), $urandom()};
    it.seed      = {$urandom(), $urandom()};
    pick = $urandom_range(0, 99);
    if (pick < 15) it.mode = MODE_RAW;
    else if (pick < 35) it.mode = MODE_RANGE;
    else if (pick < 45) it.mode = MODE_BOOL;
    else if (pick < 60) it.mode = MODE_CHANCE;
    else if (pick < 75) it.mode = MODE_DICE;
    else if (pick < 90) it.mode = MODE_DICE_SUM;
    else if (pick < 95) it.mode = MODE_SEED;
    else it.mode = MODE_RESERVED;
    sub = $urandom_range(0, 9);
    case (it.mode)
      MODE_RANGE: begin
        if (sub < 3) begin
          // Small window around zero, given in either order.
          it.first_op  = $urandom_range(0, 200) - 100;
          it.second_op = it.first_op + $urandom_range(0, 20);
          if (sub == 0) {it.first_op, it.second_op} = {it.second_op, it.first_op};
        end else if (sub == 3) begin
          it.first_op  = $urandom_range(0, 1) ? INT32_MIN : INT32_MAX;
          it.second_op = $urandom_range(0, 1) ? INT32_MIN : INT32_MAX;
        end else if (sub == 4) begin
          it.second_op = it.first_op;
        end else if (sub == 5) begin
          // Span of an exact power of two.
          it.first_op  = $urandom_range(0, 1000);
          it.second_op = it.first_op + (32'd1 << $urandom_range(0, 30)) - 32'd1;
        end
      end
      MODE_CHANCE: begin
        if (sub == 0) it.prob = 33'd0;
        else if (sub == 1) it.prob = PROB_ONE;
        else if (sub == 2) it.prob = {1'b1, $urandom()};
        else if (sub == 3) it.prob = {1'b0, 32'h8000_0000};
      end
      MODE_DICE: it.second_op = random_sides();
      MODE_DICE_SUM: begin
        it.second_op = random_sides();
        pick = $urandom_range(0, 99);
        // Long sums cost a draw and a remainder pass per die, so most sums stay short.
        if (pick < 80) it.first_op = $urandom_range(1, 4);
        else if (pick < 92) it.first_op = $urandom_range(5, 24);
        else if (pick < 97) it.first_op = $urandom_range(0, 1) ? 32'd0 : {1'b1, 31'($urandom())};
        else if (pick < 98) it.first_op = XRRU_MAX_DICE;
        // The remaining few keep a full random count, clamped one way or the other.
      end
      MODE_SEED: begin
        if (sub == 0 && $urandom_range(0, 1)) it.seed = 64'd0;
        else if (sub == 1) it.seed = '1;
      end
      default: ;
    endcase
    return it;
  endfunction

  function automatic void queue_random(int n);
    for (int i = 0; i < n; i++) pending_q.push_back(random_request());
  endfunction

  // The seed register is written only while the block is idle.
  task automatic write_seed_reg(logic [63:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    boot_seed  = value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Returns once every queued request has been taken and answered.
  task automatic wait_drained();
    while (pending_q.size() != 0 || req_if.valid || expected_q.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: offers the next pending word at the falling edge once the
  // previous one was taken, with random idle bursts between words.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    req_item_t nxt;
    logic      nxt_valid;
    if (rst_n === 1'b1 && (!req_if.valid || req_fire)) begin
      nxt_valid = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_q.size() != 0) begin
        nxt       = pending_q.pop_front();
        nxt_valid = 1'b1;
        req_if.mode           <= nxt.mode;
        req_if.first_operand  <= nxt.first_op;
        req_if.second_operand <= nxt.second_op;
        req_if.probability    <= nxt.prob;
        req_if.seed_value     <= nxt.seed;
        if (!quiet_tail && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, BURST_MAX);
      end
      req_if.valid <= nxt_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: ready comes and goes in random bursts. A long hold, when
  // requested, is counted here so that the block backs up into its input.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    logic nxt_ready;
    nxt_ready = 1'b1;
    if (hold_left > 0) begin
      hold_left--;
      nxt_ready = 1'b0;
    end else if (hold_token != hold_served) begin
      hold_served = hold_token;
      hold_left   = LONG_HOLD_CYCLES - 1;
      nxt_ready   = 1'b0;
    end else if (!quiet_tail) begin
      if (stall_left > 0) begin
        stall_left--;
        nxt_ready = 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, BURST_MAX) - 1;
        nxt_ready  = 1'b0;
      end
    end
    rsp_if.ready <= nxt_ready;
  end

  // ---------------------------------------------------------------------------
  // Monitor: at each rising edge, an accepted request feeds the predictor and
  // an accepted result is compared with the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    draw_result_t want;
    if (rst_n !== 1'b1) begin
      req_fire <= 1'b0;
    end else begin
      req_fire <= req_if.valid && req_if.ready;
      if (req_if.valid && req_if.ready) begin
        expected_q.push_back(predict_draw({req_if.mode, req_if.first_operand,
                                           req_if.second_operand, req_if.probability,
                                           req_if.seed_value}));
        mode_count[req_if.mode]++;
      end
      if (rsp_if.valid === 1'b1 && rsp_if.ready) begin
        results_checked++;
        if (expected_q.size() == 0) begin
          $error("result word %h with no request outstanding", rsp_if.random_word);
          error_count++;
        end else begin
          want = expected_q.pop_front();
          if (rsp_if.random_word !== want.word) begin
            $error("random_word: expected %h, actual %h", want.word, rsp_if.random_word);
            error_count++;
          end
          if (rsp_if.integer_result !== want.value) begin
            $error("integer_result: expected %h, actual %h", want.value, rsp_if.integer_result);
            error_count++;
          end
          if (rsp_if.flag !== want.flag) begin
            $error("flag: expected %b, actual %b", want.flag, rsp_if.flag);
            error_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_wdata             = '0;
    req_if.valid          = 1'b0;
    req_if.mode           = MODE_RAW;
    req_if.first_operand  = '0;
    req_if.second_operand = '0;
    req_if.probability    = '0;
    req_if.seed_value     = '0;
    rsp_if.ready          = 1'b0;
    gen_state             = '0;
    gen_seeded            = 1'b0;
    boot_seed             = XRRU_DEFAULT_SEED;
    send_gap              = 0;
    stall_left            = 0;
    hold_left             = 0;
    hold_token            = 0;
    hold_served           = 0;
    quiet_tail            = 1'b0;
    error_count           = 0;
    results_checked       = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // The first draw must pick up this seed, since no seed request comes first.
    write_seed_reg({$urandom(), $urandom() | 32'd1});

    // Directed words: first draw, range order and width, chance limits, side
    // and count clamping, the reserved mode and the stuck zero state.
    push_req(MODE_RAW, 0, 0, 0, 0);
    push_req(MODE_RAW, '1, '1, '1, '1);
    push_req(MODE_RANGE, 100, -50, 0, 0);
    push_req(MODE_RANGE, INT32_MIN, INT32_MAX, 0, 0);
    push_req(MODE_RANGE, INT32_MAX, INT32_MIN, 0, 0);
    push_req(MODE_RANGE, 7, 7, 0, 0);
    push_req(MODE_BOOL, 0, 0, 0, 0);
    push_req(MODE_CHANCE, 0, 0, 33'd0, 0);
    push_req(MODE_CHANCE, 0, 0, PROB_ONE, 0);
    push_req(MODE_CHANCE, 0, 0, '1, 0);
    push_req(MODE_CHANCE, 0, 0, {1'b0, 32'h8000_0000}, 0);
    push_req(MODE_DICE, 0, 0, 0, 0);
    push_req(MODE_DICE, 0, -5, 0, 0);
    push_req(MODE_DICE, 0, 6, 0, 0);
    push_req(MODE_DICE, 0, INT32_MAX, 0, 0);
    push_req(MODE_DICE_SUM, 0, 6, 0, 0);
    push_req(MODE_DICE_SUM, -3, 1, 0, 0);
    push_req(MODE_DICE_SUM, XRRU_MAX_DICE, INT32_MAX, 0, 0);
    push_req(MODE_DICE_SUM, 1000, 6, 0, 0);
    push_req(MODE_RESERVED, '1, '1, '1, '1);
    push_req(MODE_SEED, 0, 0, 0, 64'd0);
    push_req(MODE_RAW, 0, 0, 0, 0);
    push_req(MODE_DICE_SUM, 3, 6, 0, 0);
    push_req(MODE_SEED, 0, 0, 0, {$urandom(), $urandom()});
    push_req(MODE_RAW, 0, 0, 0, 0);
    wait_drained();

    // Random part, first phase. The receiver holds off for a long stretch at
    // the start while cheap requests keep coming, so the block backs up.
    write_seed_reg(64'd0);
    for (int i = 0; i < 20; i++) push_req(MODE_RAW, $urandom(), $urandom(), 0, 0);
    @(posedge clk);
    hold_token = hold_token + 1;
    queue_random(460);
    wait_drained();

    write_seed_reg('1);
    queue_random(480);
    wait_drained();

    // Last phase runs with both sides always willing.
    write_seed_reg({$urandom(), $urandom()});
    quiet_tail = 1'b1;
    queue_random(470);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d results checked; raw %0d, range %0d, bool %0d, chance %0d,",
             results_checked, mode_count[MODE_RAW], mode_count[MODE_RANGE],
             mode_count[MODE_BOOL], mode_count[MODE_CHANCE]);
    $display("  dice %0d, dice sum %0d, seed %0d, reserved %0d; %0d mismatches.",
             mode_count[MODE_DICE], mode_count[MODE_DICE_SUM], mode_count[MODE_SEED],
             mode_count[MODE_RESERVED], error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
